>>> hdl/tape_image_block_parser_macros.svh
// assertion macros shared by the tape image block parser
`ifndef TAPE_IMAGE_BLOCK_PARSER_MACROS_SVH
`define TAPE_IMAGE_BLOCK_PARSER_MACROS_SVH

// property checked on every rising edge outside reset
`define TIBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TIBP_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/tibp_pkg.sv
// ----------------------------------------------------------------------------
// tibp_pkg
// types, codes and constants of the tape image block parser
// ----------------------------------------------------------------------------
package tibp_pkg;

  typedef enum logic [3:0] {
    ST_SIG, ST_BLOCK, ST_GROUP, ST_TEXT, ST_ARCHIVE, ST_TONE, ST_NPULSE,
    ST_PULSE, ST_PURE, ST_RAW, ST_SKIP, ST_STD, ST_TURBO, ST_INVALID
  } tibp_state_e;

  typedef enum logic [3:0] {
    EV_TONE  = 4'd0,
    EV_PULSE = 4'd1,
    EV_STD   = 4'd2,
    EV_TURBO = 4'd3,
    EV_PURE  = 4'd4,
    EV_BYTE  = 4'd5,
    EV_DONE  = 4'd6,
    EV_END   = 4'd7,
    EV_ERROR = 4'd8
  } tibp_event_e;

  // block ids
  localparam logic [7:0] ID_STD     = 8'h10;
  localparam logic [7:0] ID_TURBO   = 8'h11;
  localparam logic [7:0] ID_TONE    = 8'h12;
  localparam logic [7:0] ID_PULSES  = 8'h13;
  localparam logic [7:0] ID_PURE    = 8'h14;
  localparam logic [7:0] ID_GRP_BEG = 8'h21;
  localparam logic [7:0] ID_GRP_END = 8'h22;
  localparam logic [7:0] ID_TEXT    = 8'h30;
  localparam logic [7:0] ID_ARCHIVE = 8'h32;

  // "ZXTape!" then 0x1a, first byte in the low bits
  localparam logic [63:0] SIGNATURE = 64'h1A21_6570_6154_585A;

  localparam int unsigned FIELD_DEPTH = 18;
  localparam int unsigned FILL_W      = 5;

  // header lengths in bytes
  localparam logic [FILL_W-1:0] LEN_SIG     = 5'd10;
  localparam logic [FILL_W-1:0] LEN_ARCHIVE = 5'd2;
  localparam logic [FILL_W-1:0] LEN_TONE    = 5'd4;
  localparam logic [FILL_W-1:0] LEN_PULSE   = 5'd2;
  localparam logic [FILL_W-1:0] LEN_PURE    = 5'd10;
  localparam logic [FILL_W-1:0] LEN_STD     = 5'd4;
  localparam logic [FILL_W-1:0] LEN_TURBO   = 5'd18;

  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_AW    = 2;
  localparam int unsigned EVQ_CW    = 3;

  typedef struct packed {
    tibp_event_e  kind;
    logic [15:0]  word_a;
    logic [15:0]  word_b;
    logic [15:0]  word_c;
    logic [15:0]  word_d;
    logic [15:0]  word_e;
    logic [15:0]  word_f;
    logic [15:0]  word_g;
    logic [23:0]  payload_length;
    logic [7:0]   small_value;
    logic         last_in_run;
  } tibp_event_t;

  // events raised by one request, the second only ever data done
  typedef struct packed {
    logic [1:0]  count;
    tibp_event_t first;
    tibp_event_t second;
  } tibp_ev_pair_t;

  function automatic logic [15:0] le16(input logic [7:0] lo, input logic [7:0] hi);
    return {hi, lo};
  endfunction

endpackage

>>> hdl/tibp_byte_if.sv
// ----------------------------------------------------------------------------
// tibp_byte_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface tibp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

>>> hdl/tibp_event_if.sv
// ----------------------------------------------------------------------------
// tibp_event_if
// event channel out of the parser
// ----------------------------------------------------------------------------
interface tibp_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic [15:0] word_e;
  logic [15:0] word_f;
  logic [15:0] word_g;
  logic [23:0] payload_length;
  logic [7:0]  small_value;
  logic        last_in_run;

  modport source (
    output valid, output event_kind, output word_a, output word_b, output word_c,
    output word_d, output word_e, output word_f, output word_g,
    output payload_length, output small_value, output last_in_run, input ready
  );
  modport sink (
    input valid, input event_kind, input word_a, input word_b, input word_c,
    input word_d, input word_e, input word_f, input word_g,
    input payload_length, input small_value, input last_in_run, output ready
  );
endinterface

>>> hdl/tibp_parse.sv
// ----------------------------------------------------------------------------
// tibp_parse
// parse state, header field capture and event generation for one byte
// ----------------------------------------------------------------------------
`include "tape_image_block_parser_macros.svh"

module tibp_parse
  import tibp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  input  logic          eos_i,
  output tibp_ev_pair_t ev_o
);

  tibp_state_e       state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [23:0]       rem_q, rem_d;
  logic [7:0]        ptot_q, ptot_d;
  logic [7:0]        pseen_q, pseen_d;
  logic [7:0]        fb_q [FIELD_DEPTH];
  logic [7:0]        fb_v [FIELD_DEPTH];

  logic [FILL_W-1:0] need;
  logic [FILL_W-1:0] fill_inc;
  logic              gdone;
  logic              fb_we;
  logic              start_pay;
  logic [23:0]       pay_len;
  logic [23:0]       rem_dec;
  logic [7:0]        pseen_inc;
  tibp_ev_pair_t     ev;

  // buffer as seen with the current byte already in place
  always_comb begin
    for (int i = 0; i < FIELD_DEPTH; i++) begin
      fb_v[i] = (fill_q == FILL_W'(i)) ? byte_i : fb_q[i];
    end
  end

  always_comb begin
    case (state_q)
      ST_SIG:     need = LEN_SIG;
      ST_ARCHIVE: need = LEN_ARCHIVE;
      ST_TONE:    need = LEN_TONE;
      ST_PULSE:   need = LEN_PULSE;
      ST_PURE:    need = LEN_PURE;
      ST_STD:     need = LEN_STD;
      ST_TURBO:   need = LEN_TURBO;
      default:    need = LEN_TURBO;
    endcase
  end

  assign fill_inc  = fill_q + 5'd1;
  assign gdone     = (fill_inc >= need);
  assign rem_dec   = (rem_q != 24'd0) ? (rem_q - 24'd1) : 24'd0;
  assign pseen_inc = pseen_q + 8'd1;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    ptot_d    = ptot_q;
    pseen_d   = pseen_q;
    fb_we     = 1'b0;
    start_pay = 1'b0;
    pay_len   = 24'd0;
    ev        = '0;

    if (eos_i) begin
      ev.count      = 2'd1;
      ev.first.kind = EV_END;
    end else begin
      case (state_q)
        ST_SIG: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            if ({fb_v[7], fb_v[6], fb_v[5], fb_v[4],
                 fb_v[3], fb_v[2], fb_v[1], fb_v[0]} != SIGNATURE) begin
              state_d       = ST_INVALID;
              ev.count      = 2'd1;
              ev.first.kind = EV_ERROR;
            end else begin
              state_d = ST_BLOCK;
            end
          end
        end
        ST_BLOCK: begin
          fill_d = '0;
          case (byte_i)
            ID_TEXT:    state_d = ST_TEXT;
            ID_ARCHIVE: state_d = ST_ARCHIVE;
            ID_STD:     state_d = ST_STD;
            ID_TURBO:   state_d = ST_TURBO;
            ID_TONE:    state_d = ST_TONE;
            ID_PULSES:  state_d = ST_NPULSE;
            ID_PURE:    state_d = ST_PURE;
            ID_GRP_BEG: state_d = ST_GROUP;
            ID_GRP_END: state_d = ST_BLOCK;
            default: begin
              state_d       = ST_INVALID;
              ev.count      = 2'd1;
              ev.first.kind = EV_ERROR;
            end
          endcase
        end
        ST_GROUP, ST_TEXT: begin
          rem_d   = {16'd0, byte_i};
          state_d = (byte_i != 8'd0) ? ST_SKIP : ST_BLOCK;
        end
        ST_ARCHIVE: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            rem_d   = {8'd0, le16(fb_v[0], fb_v[1])};
            state_d = (le16(fb_v[0], fb_v[1]) != 16'd0) ? ST_SKIP : ST_BLOCK;
          end
        end
        ST_TONE: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            ev.count        = 2'd1;
            ev.first.kind   = EV_TONE;
            ev.first.word_a = le16(fb_v[0], fb_v[1]);
            ev.first.word_b = le16(fb_v[2], fb_v[3]);
            state_d         = ST_BLOCK;
          end
        end
        ST_NPULSE: begin
          ptot_d  = byte_i;
          pseen_d = 8'd0;
          state_d = (byte_i != 8'd0) ? ST_PULSE : ST_BLOCK;
        end
        ST_PULSE: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            pseen_d         = pseen_inc;
            ev.count        = 2'd1;
            ev.first.kind   = EV_PULSE;
            ev.first.word_a = le16(fb_v[0], fb_v[1]);
            if (pseen_inc == ptot_q) begin
              ev.first.last_in_run = 1'b1;
              state_d              = ST_BLOCK;
            end
          end
        end
        ST_PURE: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            start_pay            = 1'b1;
            pay_len              = {fb_v[9], fb_v[8], fb_v[7]};
            ev.count             = 2'd1;
            ev.first.kind        = EV_PURE;
            ev.first.word_a      = le16(fb_v[0], fb_v[1]);
            ev.first.word_b      = le16(fb_v[2], fb_v[3]);
            ev.first.word_c      = le16(fb_v[5], fb_v[6]);
            ev.first.small_value = fb_v[4];
          end
        end
        ST_STD: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            start_pay       = 1'b1;
            pay_len         = {8'd0, le16(fb_v[2], fb_v[3])};
            ev.count        = 2'd1;
            ev.first.kind   = EV_STD;
            ev.first.word_a = le16(fb_v[0], fb_v[1]);
          end
        end
        ST_TURBO: begin
          fb_we  = 1'b1;
          fill_d = gdone ? '0 : fill_inc;
          if (gdone) begin
            start_pay            = 1'b1;
            pay_len              = {fb_v[17], fb_v[16], fb_v[15]};
            ev.count             = 2'd1;
            ev.first.kind        = EV_TURBO;
            ev.first.word_a      = le16(fb_v[0], fb_v[1]);
            ev.first.word_b      = le16(fb_v[2], fb_v[3]);
            ev.first.word_c      = le16(fb_v[4], fb_v[5]);
            ev.first.word_d      = le16(fb_v[6], fb_v[7]);
            ev.first.word_e      = le16(fb_v[8], fb_v[9]);
            ev.first.word_f      = le16(fb_v[10], fb_v[11]);
            ev.first.word_g      = le16(fb_v[13], fb_v[14]);
            ev.first.small_value = fb_v[12];
          end
        end
        ST_RAW: begin
          rem_d                = rem_dec;
          ev.count             = 2'd1;
          ev.first.kind        = EV_BYTE;
          ev.first.small_value = byte_i;
          if (rem_dec == 24'd0) begin
            ev.first.last_in_run = 1'b1;
            ev.count             = 2'd2;
            ev.second.kind       = EV_DONE;
            state_d              = ST_BLOCK;
          end
        end
        ST_SKIP: begin
          rem_d = rem_dec;
          if (rem_dec == 24'd0) begin
            state_d = ST_BLOCK;
          end
        end
        ST_INVALID: begin
          state_d = ST_INVALID;
        end
        default: begin
          state_d = ST_INVALID;
        end
      endcase

      // header done: an empty payload finishes in the same request
      if (start_pay) begin
        rem_d                   = pay_len;
        ev.first.payload_length = pay_len;
        if (pay_len == 24'd0) begin
          ev.count       = 2'd2;
          ev.second.kind = EV_DONE;
          state_d        = ST_BLOCK;
        end else begin
          state_d = ST_RAW;
        end
      end
    end
  end

  assign ev_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SIG;
      fill_q  <= '0;
      rem_q   <= '0;
      ptot_q  <= '0;
      pseen_q <= '0;
    end else if (take_i) begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      ptot_q  <= ptot_d;
      pseen_q <= pseen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && fb_we) begin
      fb_q[fill_q] <= byte_i;
    end
  end

  `TIBP_ASSERT(a_invalid_sticks, clk_i, rst_ni, (state_q == ST_INVALID) |=> (state_q == ST_INVALID), "parser left invalid state")
  `TIBP_ASSERT(a_second_is_done, clk_i, rst_ni, (ev.count == 2'd2) |-> (ev.second.kind == EV_DONE), "second event is not data done")
  `TIBP_NEVER(a_fill_range, clk_i, rst_ni, fill_q >= FILL_W'(FIELD_DEPTH), "field buffer fill out of range")

endmodule

>>> hdl/tibp_evq.sv
// ----------------------------------------------------------------------------
// tibp_evq
// event queue, takes up to two events a cycle and gives one a cycle while the sink is ready
// ----------------------------------------------------------------------------
`include "tape_image_block_parser_macros.svh"

module tibp_evq
  import tibp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tibp_ev_pair_t pair_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output tibp_event_t   head_o
);

  tibp_event_t       ent_q [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_q, wr_d;
  logic [EVQ_AW-1:0] rd_q, rd_d;
  logic [EVQ_CW-1:0] cnt_q, cnt_d;
  logic              pop;
  logic [1:0]        n_push;

  assign n_push  = push_i ? pair_i.count : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = ent_q[rd_q];
  // room for a full pair regardless of the drain this cycle
  assign room_o  = (cnt_q <= EVQ_CW'(EVQ_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + EVQ_AW'(n_push);
    rd_d  = pop ? rd_q + EVQ_AW'(1) : rd_q;
    cnt_d = cnt_q + EVQ_CW'(n_push) - EVQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      ent_q[wr_q] <= pair_i.first;
    end
    if (n_push == 2'd2) begin
      ent_q[wr_q + EVQ_AW'(1)] <= pair_i.second;
    end
  end

  `TIBP_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > EVQ_CW'(EVQ_DEPTH), "event queue overfilled")
  `TIBP_ASSERT(a_ptr_match, clk_i, rst_ni, (cnt_q != EVQ_CW'(EVQ_DEPTH)) |-> (cnt_q[EVQ_AW-1:0] == EVQ_AW'(wr_q - rd_q)), "queue pointers disagree with count")

endmodule

>>> hdl/tape_image_block_parser.sv
// Tape image block parser. Takes one byte of a tape image file per request
// (or an end-of-stream mark) and returns header, tone, pulse, payload byte,
// data done, end and error events. A request can be taken every cycle: the
// byte sits in an input register, one pass of parse logic updates the state
// and writes one or two events into a four-entry event queue, and the queue
// gives one event per cycle while the sink is ready. A request is held in
// the input register only while the queue lacks room for two events, so a
// request that raises two events (a header with an empty payload, or the
// last payload byte) fills two queue entries. An event enters the queue as
// its byte is taken. The field buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
// tape_image_block_parser
// top level: input register, parse pass and event queue
// ----------------------------------------------------------------------------
`include "tape_image_block_parser_macros.svh"

module tape_image_block_parser
  import tibp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tibp_byte_if.sink    stream_i,
  tibp_event_if.source event_o
);

  logic          in_vld_q;
  logic [7:0]    byte_q;
  logic          eos_q;
  logic          take;
  logic          room;
  tibp_ev_pair_t pair;
  tibp_event_t   head;

  assign take           = in_vld_q && room;
  assign stream_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (stream_i.ready) begin
      in_vld_q <= stream_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_i.ready && stream_i.valid) begin
      byte_q <= stream_i.stream_byte;
      eos_q  <= stream_i.end_of_stream;
    end
  end

  tibp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (byte_q),
    .eos_i  (eos_q),
    .ev_o   (pair)
  );

  tibp_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (event_o.valid),
    .ready_i (event_o.ready),
    .head_o  (head)
  );

  assign event_o.event_kind     = head.kind;
  assign event_o.word_a         = head.word_a;
  assign event_o.word_b         = head.word_b;
  assign event_o.word_c         = head.word_c;
  assign event_o.word_d         = head.word_d;
  assign event_o.word_e         = head.word_e;
  assign event_o.word_f         = head.word_f;
  assign event_o.word_g         = head.word_g;
  assign event_o.payload_length = head.payload_length;
  assign event_o.small_value    = head.small_value;
  assign event_o.last_in_run    = head.last_in_run;

  `TIBP_ASSERT(a_held_request, clk_i, rst_ni, (in_vld_q && !take) |=> (in_vld_q && $stable(byte_q) && $stable(eos_q)), "waiting request lost")

endmodule
